/* rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the slot pool allocator.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int POOL_SLOTS_DEF = 256;

    localparam int SLOT_W  = 8;
    localparam int STAMP_W = 31;
    localparam int EVICT_W = 9;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [SLOT_W-1:0]  slot_index;
        logic [STAMP_W-1:0] timestamp;
    } input_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        logic [EVICT_W-1:0] evicted_count;
        logic               error;
    } result_t;

endpackage

/* rtl/pal_ram.sv */
// ----------------------------------------------------------------------------
// pal_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/pal_seq.sv */
// ----------------------------------------------------------------------------
// pal_seq
// Sequencer and link memories: free list, active list walk, eviction loop.
// ----------------------------------------------------------------------------
module pal_seq #(
    parameter int POOL_SLOTS = pal_pkg::POOL_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pal_pkg::input_t  s_data,
    output logic             res_valid,
    input  logic             res_ready,
    output pal_pkg::result_t res
);

    localparam int IW   = $clog2(POOL_SLOTS);
    localparam int LW   = $clog2(POOL_SLOTS + 1);
    localparam int CMPW = (LW > pal_pkg::SLOT_W) ? LW : pal_pkg::SLOT_W;
    localparam int AXW  = (IW > pal_pkg::SLOT_W) ? IW : pal_pkg::SLOT_W;
    localparam int CNTW = (LW > pal_pkg::EVICT_W) ? LW : pal_pkg::EVICT_W;
    localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);

    typedef enum logic [3:0] {
        IDLE, FR_RD, FR_CHK, REL1, REL2, EV_RD, EV_CHK, AL_RD, AL_WR1, AL_WR2, DONE
    } state_t;

    state_t                      state_reg;
    logic                        mode_reg;
    logic [pal_pkg::SLOT_W-1:0]  idx_reg;
    logic [pal_pkg::STAMP_W-1:0] stamp_reg;
    logic [pal_pkg::STAMP_W-1:0] t_reg;
    logic                        first_reg;
    logic                        err_reg;
    logic [LW-1:0]               cnt_reg;
    logic [LW-1:0]               cur_reg;
    logic [LW-1:0]               before_reg;
    logic [LW-1:0]               after_reg;
    logic [LW-1:0]               free_head_reg;
    logic [LW-1:0]               newest_reg;
    logic [LW-1:0]               oldest_reg;
    logic [LW-1:0]               fresh_reg;

    logic [IW-1:0]               rd_addr;
    logic                        nx_we, pv_we, use_we, stp_we;
    logic [IW-1:0]               nx_wa, pv_wa, use_wa, stp_wa;
    logic [LW-1:0]               nx_wd, pv_wd;
    logic                        use_wd;
    logic [LW-1:0]               nx_q, pv_q;
    logic                        use_q;
    logic [pal_pkg::STAMP_W-1:0] stp_q;

    logic [AXW-1:0]              idx_ext;
    logic [IW-1:0]               idx_addr;
    logic [AXW-1:0]              cur_ext;
    logic [CNTW-1:0]             cnt_ext;
    logic                        fh_touched;

    assign idx_ext    = AXW'(idx_reg);
    assign idx_addr   = idx_ext[IW-1:0];
    assign cur_ext    = AXW'(cur_reg[IW-1:0]);
    assign cnt_ext    = CNTW'(cnt_reg);
    assign fh_touched = free_head_reg < fresh_reg;

    pal_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_next (
        .aclk(aclk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
        .rd_addr(rd_addr), .rd_data(nx_q)
    );

    pal_ram #(.WIDTH(LW), .DEPTH(POOL_SLOTS)) u_prev (
        .aclk(aclk), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
        .rd_addr(rd_addr), .rd_data(pv_q)
    );

    pal_ram #(.WIDTH(1), .DEPTH(POOL_SLOTS)) u_use (
        .aclk(aclk), .wr_en(use_we), .wr_addr(use_wa), .wr_data(use_wd),
        .rd_addr(rd_addr), .rd_data(use_q)
    );

    pal_ram #(.WIDTH(pal_pkg::STAMP_W), .DEPTH(POOL_SLOTS)) u_stamp (
        .aclk(aclk), .wr_en(stp_we), .wr_addr(stp_wa), .wr_data(stamp_reg),
        .rd_addr(rd_addr), .rd_data(stp_q)
    );

    always_comb begin
        rd_addr = '0;
        nx_we   = 1'b0;
        nx_wa   = cur_reg[IW-1:0];
        nx_wd   = free_head_reg;
        pv_we   = 1'b0;
        pv_wa   = cur_reg[IW-1:0];
        pv_wd   = NULL_LINK;
        use_we  = 1'b0;
        use_wa  = cur_reg[IW-1:0];
        use_wd  = 1'b0;
        stp_we  = 1'b0;
        stp_wa  = cur_reg[IW-1:0];
        case (state_reg)
            FR_RD: begin
                rd_addr = idx_addr;
            end
            EV_RD: begin
                rd_addr = oldest_reg[IW-1:0];
            end
            AL_RD: begin
                rd_addr = free_head_reg[IW-1:0];
            end
            REL1: begin
                nx_we  = before_reg != NULL_LINK;
                nx_wa  = before_reg[IW-1:0];
                nx_wd  = after_reg;
                pv_we  = after_reg != NULL_LINK;
                pv_wa  = after_reg[IW-1:0];
                pv_wd  = before_reg;
                use_we = 1'b1;
            end
            REL2: begin
                nx_we = 1'b1;
            end
            AL_WR1: begin
                nx_we  = 1'b1;
                nx_wd  = newest_reg;
                pv_we  = 1'b1;
                use_we = 1'b1;
                use_wd = 1'b1;
                stp_we = 1'b1;
            end
            AL_WR2: begin
                pv_we = newest_reg != NULL_LINK;
                pv_wa = newest_reg[IW-1:0];
                pv_wd = cur_reg;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            free_head_reg <= '0;
            newest_reg    <= NULL_LINK;
            oldest_reg    <= NULL_LINK;
            fresh_reg     <= '0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_data.mode;
                        idx_reg   <= s_data.slot_index;
                        stamp_reg <= s_data.timestamp;
                        cnt_reg   <= '0;
                        err_reg   <= 1'b0;
                        first_reg <= 1'b1;
                        if (s_data.mode == pal_pkg::MODE_FREE) begin
                            state_reg <= FR_RD;
                        end else if (free_head_reg == NULL_LINK) begin
                            state_reg <= EV_RD;
                        end else begin
                            state_reg <= AL_RD;
                        end
                    end
                end
                FR_RD: begin
                    if (CMPW'(idx_reg) >= CMPW'(fresh_reg)) begin
                        err_reg   <= 1'b1;
                        state_reg <= DONE;
                    end else begin
                        state_reg <= FR_CHK;
                    end
                end
                FR_CHK: begin
                    if (!use_q) begin
                        err_reg   <= 1'b1;
                        state_reg <= DONE;
                    end else begin
                        cur_reg    <= LW'(idx_addr);
                        before_reg <= pv_q;
                        after_reg  <= nx_q;
                        state_reg  <= REL1;
                    end
                end
                REL1: begin
                    if (before_reg == NULL_LINK) begin
                        newest_reg <= after_reg;
                    end
                    if (after_reg == NULL_LINK) begin
                        oldest_reg <= before_reg;
                    end
                    state_reg <= REL2;
                end
                REL2: begin
                    free_head_reg <= cur_reg;
                    state_reg     <= (mode_reg == pal_pkg::MODE_ALLOC) ? EV_RD : DONE;
                end
                EV_RD: begin
                    state_reg <= (oldest_reg == NULL_LINK) ? AL_RD : EV_CHK;
                end
                EV_CHK: begin
                    if (first_reg || stp_q == t_reg) begin
                        t_reg      <= stp_q;
                        first_reg  <= 1'b0;
                        cur_reg    <= oldest_reg;
                        before_reg <= pv_q;
                        after_reg  <= NULL_LINK;
                        cnt_reg    <= cnt_reg + LW'(1);
                        state_reg  <= REL1;
                    end else begin
                        state_reg <= AL_RD;
                    end
                end
                AL_RD: begin
                    cur_reg   <= free_head_reg;
                    state_reg <= AL_WR1;
                end
                AL_WR1: begin
                    if (fh_touched) begin
                        free_head_reg <= nx_q;
                    end else begin
                        free_head_reg <= free_head_reg + LW'(1);
                        fresh_reg     <= fresh_reg + LW'(1);
                    end
                    state_reg <= AL_WR2;
                end
                AL_WR2: begin
                    if (newest_reg == NULL_LINK) begin
                        oldest_reg <= cur_reg;
                    end
                    newest_reg <= cur_reg;
                    state_reg  <= DONE;
                end
                DONE: begin
                    if (res_ready) begin
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign s_ready   = state_reg == IDLE;
    assign res_valid = state_reg == DONE;

    always_comb begin
        res.granted_slot  = (mode_reg == pal_pkg::MODE_ALLOC) ?
                            cur_ext[pal_pkg::SLOT_W-1:0] : idx_reg;
        res.evicted_count = cnt_ext[pal_pkg::EVICT_W-1:0];
        res.error         = err_reg;
    end

    a_list_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (newest_reg == NULL_LINK) == (oldest_reg == NULL_LINK))
        else $error("active list ends disagree on emptiness");

    a_alloc_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == AL_RD) |-> (free_head_reg != NULL_LINK))
        else $error("allocation reached with empty free list");

    a_fresh_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fresh_reg >= $past(fresh_reg) && fresh_reg <= NULL_LINK))
        else $error("untouched slot mark moved backward or past pool");

    a_evict_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EV_CHK) |-> (oldest_reg != NULL_LINK && cnt_reg < NULL_LINK))
        else $error("eviction walked past the active list");

endmodule

/* rtl/pool_allocator_oldest_evict.sv */
// Requests: one in flight at a time, set by the single read port of the link memories;
// a finished result waits in the output register while the next request is taken.
// Reset: synchronous; the pool is ready once reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
// pool_allocator_oldest_evict
// Slot pool with LIFO free list and oldest-first eviction; output register.
// ----------------------------------------------------------------------------
module pool_allocator_oldest_evict #(
    parameter int POOL_SLOTS = pal_pkg::POOL_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  pal_pkg::input_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output pal_pkg::result_t m_data
);

    logic             res_valid;
    logic             res_ready;
    pal_pkg::result_t res;
    logic             m_valid_reg;
    pal_pkg::result_t m_data_reg;

    pal_seq #(.POOL_SLOTS(POOL_SLOTS)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* bench/pool_allocator_oldest_evict_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_allocator_oldest_evict_tb
// Drives alloc and free requests into the slot pool and checks each result
// against a shadow copy of the free list and the newest-to-oldest active
// list. Covers plain alloc/free, bad frees, a full pool evicting runs of
// equal stamps, and a whole-pool eviction, under several idle patterns.
// ----------------------------------------------------------------------------
module pool_allocator_oldest_evict_tb;

    localparam int         NSLOT       = 256;
    localparam logic [8:0] NIL         = 9'd256;
    localparam int         CYCLE_LIMIT = 1000000;

    logic             aclk    = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    pal_pkg::input_t  s_data  = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    pal_pkg::result_t m_data;

    pal_pkg::input_t  req_q[$];
    pal_pkg::result_t grant_q[$];
    int      send_idle  = 0;
    int      recv_stall = 0;
    int      mismatches = 0;
    int      cycle_cnt  = 0;

    logic [8:0]  lnk_next[0:NSLOT-1];
    logic [8:0]  lnk_prev[0:NSLOT-1];
    logic [30:0] stamp_mem[0:NSLOT-1];
    logic        busy[0:NSLOT-1];
    logic [8:0]  free_top;
    logic [8:0]  head_new;
    logic [8:0]  tail_old;
    logic [30:0] stamp_now = '0;

    pool_allocator_oldest_evict i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++) begin
            lnk_next[i]  = 9'(i + 1);
            lnk_prev[i]  = NIL;
            stamp_mem[i] = '0;
            busy[i]      = 1'b0;
        end
        lnk_next[NSLOT-1] = NIL;
        free_top = '0;
        head_new = NIL;
        tail_old = NIL;
    endfunction

    // unlink an active slot and push it onto the free list
    function automatic void slot_release(input logic [8:0] s);
        logic [8:0] up;
        logic [8:0] dn;
        up = lnk_prev[s];
        dn = lnk_next[s];
        if (up != NIL) lnk_next[up] = dn;
        else head_new = dn;
        if (dn != NIL) lnk_prev[dn] = up;
        else tail_old = up;
        lnk_next[s] = free_top;
        lnk_prev[s] = NIL;
        busy[s]     = 1'b0;
        free_top    = s;
    endfunction

    function automatic pal_pkg::result_t pool_apply(input pal_pkg::input_t req);
        pal_pkg::result_t r;
        logic [30:0]      t;
        logic [8:0]       s;
        int unsigned      n;
        r = '0;
        n = 0;
        if (req.mode == pal_pkg::MODE_FREE) begin
            r.granted_slot = req.slot_index;
            r.error        = 1'b1;
            if (busy[req.slot_index]) begin
                slot_release({1'b0, req.slot_index});
                r.error = 1'b0;
            end
            return r;
        end
        if (free_top == NIL && tail_old != NIL) begin
            t = stamp_mem[tail_old];
            while (tail_old != NIL && stamp_mem[tail_old] == t) begin
                slot_release(tail_old);
                n++;
            end
        end
        r.evicted_count = n[pal_pkg::EVICT_W-1:0];
        s = free_top;
        if (s != NIL) begin
            free_top    = lnk_next[s];
            lnk_next[s] = head_new;
            lnk_prev[s] = NIL;
            if (head_new != NIL) lnk_prev[head_new] = s;
            else tail_old = s;
            head_new     = s;
            stamp_mem[s] = req.timestamp;
            busy[s]      = 1'b1;
            r.granted_slot = s[7:0];
        end
        return r;
    endfunction

    // driver: predict on each accepted transfer, then launch the next request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) grant_q.push_back(pool_apply(s_data));
            if (!s_valid || s_ready) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_data  <= req_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
            if (m_valid && m_ready) begin
                if (grant_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result slot %0d evicted %0d error %0b",
                             $time, m_data.granted_slot, m_data.evicted_count, m_data.error);
                end else begin
                    pal_pkg::result_t want;
                    want = grant_q.pop_front();
                    if (m_data !== want) begin
                        mismatches++;
                        $write("%0t: mismatch expected slot %0d evicted %0d error %0b,",
                               $time, want.granted_slot, want.evicted_count, want.error);
                        $display(" got slot %0d evicted %0d error %0b",
                                 m_data.granted_slot, m_data.evicted_count, m_data.error);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send(input logic m, input logic [7:0] idx, input logic [30:0] ts);
        pal_pkg::input_t req;
        while (req_q.size() != 0) @(negedge aclk);
        req.mode       = m;
        req.slot_index = idx;
        req.timestamp  = ts;
        req_q.push_back(req);
    endtask

    task automatic quiesce();
        while (req_q.size() != 0 || s_valid || grant_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_busy();
        int base;
        base = $urandom_range(NSLOT - 1);
        for (int i = 0; i < NSLOT; i++)
            if (busy[(base + i) % NSLOT]) return 8'((base + i) % NSLOT);
        return 8'(base);
    endfunction

    function automatic logic [30:0] next_stamp();
        if ($urandom_range(9) == 0) return 31'($urandom);
        if ($urandom_range(2) == 0) stamp_now = stamp_now + 31'($urandom_range(1, 3));
        return stamp_now;
    endfunction

    task automatic random_items(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 50) send(pal_pkg::MODE_ALLOC, 8'($urandom), next_stamp());
            else if (roll < 90) send(pal_pkg::MODE_FREE, pick_busy(), 31'($urandom));
            else send(pal_pkg::MODE_FREE, 8'($urandom_range(NSLOT - 1)), 31'($urandom));
        end
    endtask

    // free every active slot, refill the pool, then force one eviction
    task automatic drain_and_flood(input int run_max);
        logic snap[0:NSLOT-1];
        int   run_left;
        quiesce();
        for (int i = 0; i < NSLOT; i++) snap[i] = busy[i];
        for (int i = 0; i < NSLOT; i++)
            if (snap[i]) send(pal_pkg::MODE_FREE, 8'(i), 31'($urandom));
        run_left = 0;
        stamp_now = 31'($urandom);
        for (int i = 0; i < NSLOT; i++) begin
            if (run_max > 0 && run_left == 0) begin
                stamp_now = stamp_now + 31'($urandom_range(1, 5));
                run_left  = $urandom_range(1, run_max);
            end
            run_left--;
            send(pal_pkg::MODE_ALLOC, 8'($urandom), stamp_now);
        end
        stamp_now = stamp_now + 31'd100;
        send(pal_pkg::MODE_ALLOC, 8'($urandom), stamp_now);
    endtask

    initial begin
        pool_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send(pal_pkg::MODE_ALLOC, 8'hFF, 31'h0000_0000);
        send(pal_pkg::MODE_ALLOC, 8'h00, 31'h7FFF_FFFF);
        send(pal_pkg::MODE_ALLOC, 8'h55, 31'h2AAA_AAAA);
        send(pal_pkg::MODE_ALLOC, 8'hAA, 31'h5555_5555);
        send(pal_pkg::MODE_FREE,  8'd1,   '0);
        send(pal_pkg::MODE_FREE,  8'd1,   '0);
        send(pal_pkg::MODE_FREE,  8'd255, 31'h7FFF_FFFF);
        send(pal_pkg::MODE_FREE,  8'd0,   '0);
        send(pal_pkg::MODE_FREE,  8'd3,   '0);
        send(pal_pkg::MODE_ALLOC, 8'h00, 31'd5);
        send(pal_pkg::MODE_ALLOC, 8'h00, 31'd5);
        send(pal_pkg::MODE_FREE,  8'hAA, '0);
        send(pal_pkg::MODE_FREE,  8'd2,   '0);
        send(pal_pkg::MODE_FREE,  8'd3,   '0);
        send(pal_pkg::MODE_FREE,  8'd0,   '0);
        send(pal_pkg::MODE_FREE,  8'd0,   '0);
        send(pal_pkg::MODE_ALLOC, 8'h00, 31'd9);
        send(pal_pkg::MODE_FREE,  8'h55, '0);

        drain_and_flood(0);
        random_items(240);

        quiesce();
        send_idle = 71;
        random_items(240);

        quiesce();
        send_idle  = 0;
        recv_stall = 71;
        drain_and_flood(6);
        random_items(240);

        quiesce();
        send_idle  = 8;
        recv_stall = 8;
        random_items(240);

        quiesce();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
